>>> src/rc5_pkg.sv
package rc5_pkg;

	// Frame: start, field, toggle, five address bits, six command bits
	localparam int unsigned ADDR_W     = 5;
	localparam int unsigned CMD_W      = 7;
	localparam int unsigned FRAME_BITS = 14;
	localparam int unsigned HALF_W     = 15;
	localparam int unsigned DUR_W      = 16;
	localparam int unsigned REM_W      = 4;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;

	localparam int unsigned FIFO_DEPTH_DEF = 2;

	localparam logic [HALF_W-1:0] HALF_BIT_RST = 15'd889;
	localparam logic [DUR_W-1:0]  END_GAP_RST  = 16'd65535;

	typedef logic [FRAME_BITS-1:0] frame_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HALF_BIT = 2'd0,
		REG_END_GAP  = 2'd1
	} cfg_reg_t;

	// queue status seen by the back end
	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

	function automatic frame_t build_frame(
		input logic [ADDR_W-1:0] addr,
		input logic [CMD_W-1:0]  cmd,
		input logic              tgl
	);
		build_frame = {1'b1, ~cmd[CMD_W-1], tgl, addr, cmd[CMD_W-2:0]};
	endfunction

endpackage

>>> src/rc5_front.sv
module rc5_front import rc5_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              action,
	input  logic [ADDR_W-1:0] address,
	input  logic [CMD_W-1:0]  command,
	input  logic              toggle_in,
	input  logic              q_full,
	output logic              push,
	output frame_t            push_frame
);

	logic toggle_q;
	logic tgl;

	assign in_ready   = ~q_full;
	assign push       = in_valid & in_ready;
	// automatic mode sends the flipped kept bit
	assign tgl        = action ? toggle_in : ~toggle_q;
	assign push_frame = build_frame(address, command, tgl);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			toggle_q <= 1'b1;
		end else if (push && !action) begin
			toggle_q <= ~toggle_q;
		end
	end

endmodule

>>> src/rc5_fifo.sv
module rc5_fifo import rc5_pkg::*; #(
	parameter int unsigned DEPTH = FIFO_DEPTH_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  frame_t  push_frame,
	input  logic    pop,
	output frame_t  pop_frame,
	output q_stat_t stat
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	frame_t           mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign stat.empty = (cnt_q == '0);
	assign stat.full  = (cnt_q == CNT_FULL);
	assign pop_frame  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_frame;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

>>> src/rc5_back.sv
module rc5_back import rc5_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [HALF_W-1:0] half_bit_us,
	input  logic [DUR_W-1:0]  end_gap_us,
	input  q_stat_t           q_stat,
	input  frame_t            q_frame,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [DUR_W-1:0]  duration_us,
	output logic              is_mark,
	output logic              last
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BITS,
		ST_END
	} state_t;

	localparam logic [REM_W-1:0] REM_START = REM_W'(FRAME_BITS - 1);
	localparam logic [REM_W-1:0] REM_ONE   = REM_W'(1);

	state_t           state_q;
	frame_t           frame_q;
	logic [REM_W-1:0] rem_q;
	logic             second_q;
	logic             mark_q;
	logic             out_valid_q;
	logic [DUR_W-1:0] dur_q;
	logic             is_mark_q;
	logic             last_q;

	logic             adv;
	logic [DUR_W-1:0] half_dur;
	logic [DUR_W-1:0] dbl_dur;

	assign adv      = ~out_valid_q | out_ready;
	assign half_dur = {1'b0, half_bit_us};
	assign dbl_dur  = {half_bit_us, 1'b0};
	// take the next frame when idle or while the gap goes out
	assign pop = adv & ~q_stat.empty &
		((state_q == ST_IDLE) | ((state_q == ST_END) & ~frame_q[FRAME_BITS-1]));

	assign out_valid   = out_valid_q;
	assign duration_us = dur_q;
	assign is_mark     = is_mark_q;
	assign last        = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			frame_q     <= '0;
			rem_q       <= '0;
			second_q    <= 1'b0;
			mark_q      <= 1'b1;
			out_valid_q <= 1'b0;
			dur_q       <= '0;
			is_mark_q   <= 1'b0;
			last_q      <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						frame_q  <= q_frame;
						rem_q    <= REM_START;
						second_q <= 1'b0;
						mark_q   <= 1'b1;
						state_q  <= ST_BITS;
					end
				end
				ST_BITS: begin
					out_valid_q <= 1'b1;
					is_mark_q   <= mark_q;
					last_q      <= 1'b0;
					mark_q      <= ~mark_q;
					if (frame_q[FRAME_BITS-1] != frame_q[FRAME_BITS-2]) begin
						// a level change merges two half-bits
						dur_q   <= dbl_dur;
						frame_q <= {frame_q[FRAME_BITS-2:0], 1'b0};
						rem_q   <= rem_q - 1'b1;
						if (rem_q == REM_ONE) begin
							state_q <= ST_END;
						end
					end else if (!second_q) begin
						dur_q    <= half_dur;
						second_q <= 1'b1;
					end else begin
						dur_q    <= half_dur;
						second_q <= 1'b0;
						frame_q  <= {frame_q[FRAME_BITS-2:0], 1'b0};
						rem_q    <= rem_q - 1'b1;
						if (rem_q == REM_ONE) begin
							state_q <= ST_END;
						end
					end
				end
				ST_END: begin
					out_valid_q <= 1'b1;
					is_mark_q   <= mark_q;
					if (frame_q[FRAME_BITS-1]) begin
						// closing mark of a trailing one
						dur_q   <= half_dur;
						last_q  <= 1'b0;
						mark_q  <= ~mark_q;
						frame_q <= {frame_q[FRAME_BITS-2:0], 1'b0};
					end else begin
						dur_q  <= end_gap_us;
						last_q <= 1'b1;
						if (pop) begin
							frame_q  <= q_frame;
							rem_q    <= REM_START;
							second_q <= 1'b0;
							mark_q   <= 1'b1;
							state_q  <= ST_BITS;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> src/rc5_ir_frame_encoder.sv
// Path: request queue, then the back end's frame register, then its output register.
// Throughput: one duration word per cycle from the back-end sequencer while out_ready is high; a frame
//   is 14 to 28 words, and the next queued frame starts right after the gap.
// Requests are taken every cycle while the request queue has room.
// Reset (arst_n low, asynchronous): queue empty, no word pending, kept toggle 1,
//   half_bit_us 889, end_gap_us 65535.
module rc5_ir_frame_encoder import rc5_pkg::*; #(
	parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  action,
	input  logic [ADDR_W-1:0]     address,
	input  logic [CMD_W-1:0]      command,
	input  logic                  toggle_in,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [DUR_W-1:0]      duration_us,
	output logic                  is_mark,
	output logic                  last
);

	logic [HALF_W-1:0] half_bit_q;
	logic [DUR_W-1:0]  end_gap_q;

	logic    push;
	frame_t  push_frame;
	logic    pop;
	frame_t  pop_frame;
	q_stat_t q_stat;

	// Configuration registers; unknown indexes drop the write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_bit_q <= HALF_BIT_RST;
			end_gap_q  <= END_GAP_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_HALF_BIT: half_bit_q <= cfg_data[HALF_W-1:0];
				REG_END_GAP:  end_gap_q  <= cfg_data[DUR_W-1:0];
				default: ;
			endcase
		end
	end

	// Front end: apply the toggle rule and pack the 14-bit frame.
	rc5_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.action     (action),
		.address    (address),
		.command    (command),
		.toggle_in  (toggle_in),
		.q_full     (q_stat.full),
		.push       (push),
		.push_frame (push_frame)
	);

	// Short queue of packed frames decouples the two ends.
	rc5_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_frame (push_frame),
		.pop        (pop),
		.pop_frame  (pop_frame),
		.stat       (q_stat)
	);

	// Back end: walk the Manchester half-bits and emit one duration word a cycle while out_ready is high.
	rc5_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.half_bit_us (half_bit_q),
		.end_gap_us  (end_gap_q),
		.q_stat      (q_stat),
		.q_frame     (pop_frame),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.duration_us (duration_us),
		.is_mark     (is_mark),
		.last        (last)
	);

	// The final gap is always a space.
	a_gap_is_space: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> !is_mark)
		else $error("final gap marked as carrier on");

	// Marks are one or two half-bits long.
	a_mark_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_mark && !last |->
			(duration_us == {1'b0, half_bit_q}) || (duration_us == {half_bit_q, 1'b0}))
		else $error("mark duration is not a half-bit multiple");

	// Queue never reports full and empty together.
	a_q_stat: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue status inconsistent");

	// No pop from an empty queue.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("pop from empty queue");

endmodule

>>> bench/tb_top.sv
module tb_top import rc5_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	// Spare register indexes: writes to these must leave both registers alone
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	localparam int LIMIT_CYCLES = 200000;
	localparam int SETTLE_CYCLES = 4;
	localparam int RX_HOLD_CYCLES = 300;
	localparam int MAX_PRINTED = 40;
	localparam int N_STEPS = 20;

	typedef enum bit {
		STEP_FRAME,
		STEP_CFG
	} step_kind_t;

	// One expected duration word
	typedef struct {
		logic [DUR_W-1:0] dur;
		logic             mark;
		logic             fin;
	} dur_word_t;

	// Per-frame hand-typed check: word count and closing gap
	typedef struct {
		bit               typed;
		int               words;
		logic [DUR_W-1:0] gap;
	} frame_check_t;

	typedef struct {
		step_kind_t            kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		logic                  act;
		logic [ADDR_W-1:0]     addr;
		logic [CMD_W-1:0]      cmd;
		logic                  tin;
		bit                    typed;
		int                    words;
		logic [DUR_W-1:0]      gap;
	} step_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic                  action;
	logic [ADDR_W-1:0]     address;
	logic [CMD_W-1:0]      command;
	logic                  toggle_in;
	logic                  out_valid;
	logic                  out_ready;
	logic [DUR_W-1:0]      duration_us;
	logic                  is_mark;
	logic                  last;

	// Predictor state: our own copy of the registers and the kept toggle bit
	logic [HALF_W-1:0] half_us;
	logic [DUR_W-1:0]  gap_us;
	logic              kept_toggle;
	int                word_idx;

	dur_word_t    pending_durs[$];
	frame_check_t frame_checks[$];

	int mismatches;
	int frame_len;
	int cycle_cnt;
	int send_idle_pct;
	int recv_idle_pct;
	int rx_hold_left;

	step_t steps [N_STEPS];

	rc5_ir_frame_encoder i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.action     (action),
		.address    (address),
		.command    (command),
		.toggle_in  (toggle_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.duration_us(duration_us),
		.is_mark    (is_mark),
		.last       (last)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Print one line per mismatch (capped so a dead block cannot flood the log) and count it
	task automatic report_mismatch(input string what);
		if (mismatches < MAX_PRINTED)
			$display("MISMATCH at %0t: %s", $time, what);
		mismatches++;
	endtask

	function automatic void push_dur(input logic [DUR_W-1:0] d, input logic fin);
		dur_word_t w;
		w.dur  = d;
		w.mark = (word_idx % 2 == 0);
		w.fin  = fin;
		pending_durs.push_back(w);
		word_idx++;
	endfunction

	// Expand one request into its mark/space words. Bits go out start, field, toggle,
	// address MSB first, command[5:0] MSB first. Each boundary between two bits gives
	// two single half-bits if the bits match, one double half-bit if they differ.
	function automatic void encode_rc5_frame(
		input logic              act,
		input logic [ADDR_W-1:0] addr,
		input logic [CMD_W-1:0]  cmd,
		input logic              tin
	);
		logic [13:0] bits;
		logic        tgl;
		if (!act) begin
			kept_toggle = ~kept_toggle;
			tgl = kept_toggle;
		end else begin
			tgl = tin;
		end
		bits[13]   = 1'b1;
		bits[12]   = ~cmd[6];
		bits[11]   = tgl;
		bits[10:6] = addr;
		bits[5:0]  = cmd[5:0];
		word_idx = 0;
		for (int i = 12; i >= 0; i--) begin
			if (bits[i] == bits[i+1]) begin
				push_dur({1'b0, half_us}, 1'b0);
				push_dur({1'b0, half_us}, 1'b0);
			end else begin
				push_dur({half_us, 1'b0}, 1'b0);
			end
		end
		// a closing 1 still owes its second (mark) half; a closing 0 melts into the gap
		if (bits[0])
			push_dur({1'b0, half_us}, 1'b0);
		push_dur(gap_us, 1'b1);
	endfunction

	// Write one register; cfg_we is low again before the task returns, so two writes never run together
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_HALF_BIT: half_us = data[HALF_W-1:0];
			REG_END_GAP:  gap_us  = data;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Offer one request; return in the time step of the edge that takes it
	task automatic put_frame(
		input logic              act,
		input logic [ADDR_W-1:0] addr,
		input logic [CMD_W-1:0]  cmd,
		input logic              tin,
		input bit                typed,
		input int                words,
		input logic [DUR_W-1:0]  gap
	);
		frame_check_t fc;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		action    <= act;
		address   <= addr;
		command   <= cmd;
		toggle_in <= tin;
		// valid and ready are stable mid-cycle; a high pair means the next edge takes it
		do
			@(negedge clk);
		while (!in_ready);
		@(posedge clk);
		encode_rc5_frame(act, addr, cmd, tin);
		fc.typed = typed;
		fc.words = words;
		fc.gap   = gap;
		frame_checks.push_back(fc);
	endtask

	// Hold until every expected word has been taken, then let the pipe settle
	task automatic wait_frames_out();
		while (pending_durs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Receiver: random ready, or a long forced hold-off when asked
	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_left > 0) begin
				out_ready <= 1'b0;
				rx_hold_left--;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Check each word in the middle of the cycle before the edge that takes it
	always @(negedge clk) begin : check_words
		dur_word_t    w;
		frame_check_t fc;
		if (arst_n && out_valid && out_ready) begin
			if (pending_durs.size() == 0) begin
				report_mismatch($sformatf("word %0d/%0b/%0b with nothing expected",
					duration_us, is_mark, last));
			end else begin
				w = pending_durs.pop_front();
				if (duration_us !== w.dur)
					report_mismatch($sformatf("duration_us %0d, want %0d",
						duration_us, w.dur));
				if (is_mark !== w.mark)
					report_mismatch($sformatf("is_mark %0b, want %0b", is_mark, w.mark));
				if (last !== w.fin)
					report_mismatch($sformatf("last %0b, want %0b", last, w.fin));
			end
			frame_len++;
			if (last === 1'b1) begin
				if (frame_checks.size() == 0) begin
					report_mismatch("frame end with no request outstanding");
				end else begin
					fc = frame_checks.pop_front();
					if (fc.typed && frame_len != fc.words)
						report_mismatch($sformatf("frame of %0d words, want %0d",
							frame_len, fc.words));
					if (fc.typed && duration_us !== fc.gap)
						report_mismatch($sformatf("end gap %0d, want %0d",
							duration_us, fc.gap));
				end
				frame_len = 0;
			end
		end
	end

	// Watchdog on the whole run
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= LIMIT_CYCLES) begin
			$display("rc5_ir_frame_encoder test failed");
			$finish;
		end
	end

	initial begin
		logic [CFG_DATA_W-1:0] half_pick;
		logic [CFG_DATA_W-1:0] gap_pick;

		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_idx   = REG_HALF_BIT;
		cfg_data  = '0;
		in_valid  = 1'b0;
		action    = 1'b0;
		address   = '0;
		command   = '0;
		toggle_in = 1'b0;
		mismatches    = 0;
		frame_len     = 0;
		cycle_cnt     = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		rx_hold_left  = 0;
		half_us     = HALF_BIT_RST;
		gap_us      = END_GAP_RST;
		kept_toggle = 1'b1;
		word_idx    = 0;

		// Directed steps. Typed counts: all-ones bits give 26 single halves, a trailing
		// mark and the gap (28); one 1->0 step then all zeros gives 26; strict
		// alternation gives 13 doubles plus the gap (14).
		steps = '{
			'{STEP_FRAME, REG_HALF_BIT, 16'h0000, 1'b1, 5'h1F, 7'h3F, 1'b1, 1, 28, 16'hFFFF},
			'{STEP_FRAME, REG_HALF_BIT, 16'h0000, 1'b0, 5'h00, 7'h40, 1'b0, 1, 26, 16'hFFFF},
			'{STEP_FRAME, REG_HALF_BIT, 16'h0000, 1'b0, 5'h0A, 7'h6A, 1'b0, 1, 14, 16'hFFFF},
			'{STEP_FRAME, REG_HALF_BIT, 16'h0000, 1'b1, 5'h1F, 7'h7F, 1'b0, 0, 0, 16'h0000},
			'{STEP_FRAME, REG_HALF_BIT, 16'h0000, 1'b1, 5'h15, 7'h00, 1'b1, 0, 0, 16'h0000},
			// top bit of the half-bit write must be dropped
			'{STEP_CFG, REG_HALF_BIT, 16'hFFFF, 1'b0, 5'h00, 7'h00, 1'b0, 0, 0, 16'h0000},
			'{STEP_CFG, REG_END_GAP, 16'h0000, 1'b0, 5'h00, 7'h00, 1'b0, 0, 0, 16'h0000},
			'{STEP_FRAME, REG_HALF_BIT, 16'h0000, 1'b1, 5'h1F, 7'h3F, 1'b1, 1, 28, 16'h0000},
			'{STEP_FRAME, REG_HALF_BIT, 16'h0000, 1'b0, 5'h00, 7'h00, 1'b0, 0, 0, 16'h0000},
			// zero half-bit: same frame shape, zero-length marks and spaces
			'{STEP_CFG, REG_HALF_BIT, 16'h0000, 1'b0, 5'h00, 7'h00, 1'b0, 0, 0, 16'h0000},
			'{STEP_CFG, REG_END_GAP, 16'h5A5A, 1'b0, 5'h00, 7'h00, 1'b0, 0, 0, 16'h0000},
			'{STEP_FRAME, REG_HALF_BIT, 16'h0000, 1'b1, 5'h00, 7'h40, 1'b0, 1, 26, 16'h5A5A},
			'{STEP_FRAME, REG_HALF_BIT, 16'h0000, 1'b0, 5'h1F, 7'h55, 1'b0, 0, 0, 16'h0000},
			// unknown indexes: the gap must still read 0x5A5A afterwards
			'{STEP_CFG, REG_SPARE_A, 16'h1234, 1'b0, 5'h00, 7'h00, 1'b0, 0, 0, 16'h0000},
			'{STEP_CFG, REG_SPARE_B, 16'hA5A5, 1'b0, 5'h00, 7'h00, 1'b0, 0, 0, 16'h0000},
			'{STEP_FRAME, REG_HALF_BIT, 16'h0000, 1'b1, 5'h1F, 7'h3F, 1'b1, 1, 28, 16'h5A5A},
			'{STEP_CFG, REG_HALF_BIT, 16'h0001, 1'b0, 5'h00, 7'h00, 1'b0, 0, 0, 16'h0000},
			'{STEP_CFG, REG_END_GAP, 16'hFFFF, 1'b0, 5'h00, 7'h00, 1'b0, 0, 0, 16'h0000},
			'{STEP_FRAME, REG_HALF_BIT, 16'h0000, 1'b1, 5'h0A, 7'h6A, 1'b0, 0, 0, 16'h0000},
			'{STEP_FRAME, REG_HALF_BIT, 16'h0000, 1'b0, 5'h01, 7'h01, 1'b0, 0, 0, 16'h0000}
		};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int s = 0; s < N_STEPS; s++) begin
			if (steps[s].kind == STEP_CFG) begin
				in_valid <= 1'b0;
				wait_frames_out();
				write_reg(steps[s].idx, steps[s].data);
			end else begin
				put_frame(steps[s].act, steps[s].addr, steps[s].cmd, steps[s].tin,
					steps[s].typed, steps[s].words, steps[s].gap);
			end
		end

		// Random part: three idling regimes, two register settings each
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 25;
					recv_idle_pct = 63;
				end
				1: begin
					send_idle_pct = 63;
					recv_idle_pct = 25;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int blk = 0; blk < 2; blk++) begin
				in_valid <= 1'b0;
				wait_frames_out();
				case ($urandom_range(3))
					0: half_pick = 16'h0001;
					1: half_pick = 16'h7FFF;
					2: half_pick = 16'($urandom_range(2000, 1));
					default: half_pick = 16'($urandom);
				endcase
				case ($urandom_range(3))
					0: gap_pick = 16'h0000;
					1: gap_pick = 16'hFFFF;
					default: gap_pick = 16'($urandom);
				endcase
				write_reg(REG_HALF_BIT, half_pick);
				write_reg(REG_END_GAP, gap_pick);
				// hold the receiver off long enough to back up the request queue
				if (ph == 2 && blk == 0)
					rx_hold_left = RX_HOLD_CYCLES;
				repeat (35)
					put_frame(1'($urandom), 5'($urandom), 7'($urandom), 1'($urandom),
						1'b0, 0, '0);
			end
		end

		in_valid <= 1'b0;
		wait_frames_out();
		repeat (8) @(posedge clk);
		if (frame_checks.size() != 0)
			report_mismatch($sformatf("%0d frames never closed", frame_checks.size()));
		if (mismatches == 0)
			$display("rc5_ir_frame_encoder test passed");
		else
			$display("rc5_ir_frame_encoder test failed");
		$finish;
	end

endmodule
